// ===== sv/prr_pkg.sv =====
// shared types and constants of the polyphase rational resampler
// used by prr_datapath, prr_ctrl and the top level; no dependencies
package prr_pkg;

  localparam int CMD_W   = 2;
  localparam int CIDX_W  = 10;
  localparam int CFG_W   = 7;
  localparam int CFGA_W  = 2;
  localparam int DIV_W   = 40;
  localparam int FAC_W   = 7;
  localparam int CNT_W   = 32;
  localparam int DECIM_LIMIT  = 64;
  localparam int RESULT_LIMIT = 16;
  localparam int RES_CNT_W    = 5;

  localparam logic [CMD_W-1:0] CMD_COEF  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

  localparam logic [CFGA_W-1:0] CFG_INTERP = 2'd0;
  localparam logic [CFGA_W-1:0] CFG_DECIM  = 2'd1;
  localparam logic [CFGA_W-1:0] CFG_TAPS   = 2'd2;

  typedef struct packed {
    logic coef_wr;
    logic push_smp;
    logic push_zero;
    logic div_tgt_start;
    logic div_base_start;
    logic cap_tgt;
    logic cap_base;
    logic mac_init;
    logic mac_issue;
    logic produce;
    logic emit;
    logic emit_last;
  } cmd_t;

  typedef struct packed {
    logic flushing;
    logic div_done;
    logic stop_tgt;
    logic ready_ok;
    logic tap_last;
    logic mac_busy;
    logic held;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/prr_div.sv =====
// restoring divider, one quotient bit per cycle
// does not depend on prr_pkg; widths come from its own parameters
module prr_div #(
  parameter int DW = 40,
  parameter int VW = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o,
  output logic [VW-1:0] rem_o
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quot_q, quot_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [VW-1:0] dvs_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [VW:0]   trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quot_q[DW-1]};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      cnt_d  = CW'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = VW'(trial - {1'b0, dvs_q});
        quot_d = {quot_q[DW-2:0], 1'b1};
      end else begin
        rem_d = VW'(trial);
        quot_d = {quot_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) dvs_q <= divisor_i;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ===== sv/prr_datapath.sv =====
// datapath: config registers, coefficient and history memories, counters,
// divider, multiply-accumulate pipeline and output register; uses prr_pkg, prr_div
module prr_datapath #(
  parameter int COEF_DEPTH    = 1024,
  parameter int MAX_TAPS      = 64,
  parameter int MAX_INTERP    = 16,
  parameter int HISTORY_DEPTH = 128,
  parameter int SAMPLE_WIDTH  = 16,
  parameter int COEF_WIDTH    = 18
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [prr_pkg::CFGA_W-1:0]        cfg_index_i,
  input  logic [prr_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic [prr_pkg::CIDX_W-1:0]        coef_index_i,
  input  logic signed [COEF_WIDTH-1:0]      coef_value_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    sample_value_i,
  input  prr_pkg::cmd_t                     cmd_i,
  output prr_pkg::sts_t                     sts_o,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic signed [SAMPLE_WIDTH-1:0]    out_sample_o,
  output logic                              last_in_run_o,
  output logic                              final_output_o
);

  localparam int CA_W   = $clog2(COEF_DEPTH);
  localparam int HA_W   = $clog2(HISTORY_DEPTH);
  localparam int FRAC   = COEF_WIDTH - 2;
  localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int ACC_W  = PROD_W + 8;
  localparam int DW     = prr_pkg::DIV_W;
  localparam int FW     = prr_pkg::FAC_W;
  localparam int NW     = prr_pkg::CNT_W;
  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO =
    {{(ACC_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] RND =
    {{(ACC_W-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};

  logic [4:0]    l_raw_q;
  logic [FW-1:0] m_raw_q, t_raw_q;
  logic [FW-1:0] eff_l, eff_m, eff_t;

  logic [SAMPLE_WIDTH-1:0] hist_mem [HISTORY_DEPTH];
  logic [COEF_WIDTH-1:0]   coef_mem [COEF_DEPTH];

  logic [NW-1:0]   samples_q, outs_q, pushed_q;
  logic [HA_W-1:0] wr_ptr_q;
  logic            flushing_q;
  logic [DW-1:0]   target_q, base_q;
  logic [FW-1:0]   phase_q;

  logic          div_start, div_done;
  logic [DW-1:0] div_dividend, div_quot;
  logic [FW-1:0] div_divisor, div_rem;

  logic [NW:0]     i1;
  logic [FW-1:0]   used;
  logic [DW:0]     newest;
  logic [HA_W-1:0] haddr_q;
  logic [CA_W-1:0] caddr_q;
  logic [FW-1:0]   k_q;
  logic            v1_q, v2_q;
  logic signed [SAMPLE_WIDTH-1:0] hrd_q;
  logic signed [COEF_WIDTH-1:0]   crd_q;
  logic signed [PROD_W-1:0]       prod_q;
  logic signed [ACC_W-1:0]        acc_q, rnd_sum, shifted;
  logic signed [SAMPLE_WIDTH-1:0] sat_val;

  logic                           held_q, held_final_q;
  logic signed [SAMPLE_WIDTH-1:0] held_sample_q;
  logic                           out_valid_q, out_last_q, out_final_q;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_q;
  logic                           out_free;

  // effective factors, clamped
  always_comb begin
    if (l_raw_q == '0) eff_l = FW'(1);
    else if (int'(l_raw_q) > MAX_INTERP) eff_l = FW'(MAX_INTERP);
    else eff_l = FW'(l_raw_q);
    if (m_raw_q == '0) eff_m = FW'(1);
    else if (int'(m_raw_q) > prr_pkg::DECIM_LIMIT) eff_m = FW'(prr_pkg::DECIM_LIMIT);
    else eff_m = m_raw_q;
    if (t_raw_q == '0) eff_t = FW'(1);
    else if (int'(t_raw_q) > MAX_TAPS) eff_t = FW'(MAX_TAPS);
    else eff_t = t_raw_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_raw_q <= 5'd1;
      m_raw_q <= FW'(1);
      t_raw_q <= FW'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        prr_pkg::CFG_INTERP: l_raw_q <= cfg_data_i[4:0];
        prr_pkg::CFG_DECIM:  m_raw_q <= cfg_data_i;
        prr_pkg::CFG_TAPS:   t_raw_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // divider operands
  assign div_start = cmd_i.div_tgt_start | cmd_i.div_base_start;
  always_comb begin
    if (cmd_i.div_tgt_start) begin
      div_dividend = DW'(samples_q) * DW'(eff_l) + DW'(eff_m) - DW'(1);
      div_divisor  = eff_m;
    end else begin
      div_dividend = DW'(i1) * DW'(eff_m);
      div_divisor  = eff_l;
    end
  end

  prr_div #(.DW(DW), .VW(FW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign i1     = {1'b0, outs_q} + (NW+1)'(1);
  assign used   = (i1 < (NW+1)'(eff_t)) ? FW'(i1) : eff_t;
  assign newest = {1'b0, base_q} + (DW+1)'(used) - (DW+1)'(1);

  // counters and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samples_q  <= '0;
      outs_q     <= '0;
      pushed_q   <= '0;
      wr_ptr_q   <= '0;
      flushing_q <= 1'b0;
      held_q     <= 1'b0;
    end else begin
      if (cmd_i.push_smp || cmd_i.push_zero) begin
        pushed_q <= pushed_q + NW'(1);
        wr_ptr_q <= (wr_ptr_q == HA_W'(HISTORY_DEPTH - 1)) ? '0 : wr_ptr_q + HA_W'(1);
      end
      if (cmd_i.push_smp) samples_q <= samples_q + NW'(1);
      if (cmd_i.push_zero) flushing_q <= 1'b1;
      if (cmd_i.produce) begin
        outs_q <= outs_q + NW'(1);
        held_q <= 1'b1;
      end else if (cmd_i.emit) begin
        held_q <= 1'b0;
      end
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.coef_wr) begin
      coef_mem[CA_W'(32'(coef_index_i) % COEF_DEPTH)] <= coef_value_i;
    end
    if (cmd_i.push_smp) hist_mem[wr_ptr_q] <= sample_value_i;
    else if (cmd_i.push_zero) hist_mem[wr_ptr_q] <= '0;
    hrd_q <= hist_mem[haddr_q];
    crd_q <= coef_mem[caddr_q];
  end

  // multiply-accumulate pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.mac_issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_tgt) target_q <= div_quot;
    if (cmd_i.cap_base) begin
      base_q  <= div_quot;
      phase_q <= div_rem;
    end
    if (cmd_i.mac_init) begin
      haddr_q <= HA_W'(newest % HISTORY_DEPTH);
      caddr_q <= CA_W'(phase_q);
      k_q     <= '0;
    end else if (cmd_i.mac_issue) begin
      haddr_q <= (haddr_q == '0) ? HA_W'(HISTORY_DEPTH - 1) : haddr_q - HA_W'(1);
      caddr_q <= CA_W'((32'(caddr_q) + 32'(eff_l)) % COEF_DEPTH);
      k_q     <= k_q + FW'(1);
    end
    prod_q <= hrd_q * crd_q;
    if (cmd_i.mac_init) acc_q <= '0;
    else if (v2_q) acc_q <= acc_q + ACC_W'(prod_q);
    if (cmd_i.produce) begin
      held_sample_q <= sat_val;
      held_final_q  <= flushing_q && ({{(DW-NW){1'b0}}, outs_q + NW'(1)} == target_q);
    end
  end

  // round half up and saturate
  always_comb begin
    rnd_sum = acc_q + RND;
    shifted = rnd_sum >>> FRAC;
    if (shifted > SAT_HI) sat_val = SAT_HI[SAMPLE_WIDTH-1:0];
    else if (shifted < SAT_LO) sat_val = SAT_LO[SAMPLE_WIDTH-1:0];
    else sat_val = shifted[SAMPLE_WIDTH-1:0];
  end

  // output register
  assign out_free = !out_valid_q || out_ready_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_sample_q <= held_sample_q;
      out_last_q   <= cmd_i.emit_last;
      out_final_q  <= held_final_q;
    end
  end

  assign sts_o.flushing = flushing_q;
  assign sts_o.div_done = div_done;
  assign sts_o.stop_tgt = flushing_q && ({{(DW-NW){1'b0}}, outs_q} >= target_q);
  assign sts_o.ready_ok = newest < (DW+1)'(pushed_q);
  assign sts_o.tap_last = (k_q == used - FW'(1));
  assign sts_o.mac_busy = v1_q | v2_q;
  assign sts_o.held     = held_q;
  assign sts_o.out_free = out_free;

  assign out_valid_o    = out_valid_q;
  assign out_sample_o   = out_sample_q;
  assign last_in_run_o  = out_last_q;
  assign final_output_o = out_final_q;

endmodule

// ===== sv/prr_ctrl.sv =====
// controller state machine: request decode, output loop and tap sequencing
// uses prr_pkg command and status structs
module prr_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [prr_pkg::CMD_W-1:0]  command_i,
  input  prr_pkg::sts_t              sts_i,
  output prr_pkg::cmd_t              cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_TGT, S_TGT_W, S_CHK, S_BASE_W, S_RDY,
    S_EMIT_MID, S_MAC_INIT, S_MAC, S_DRAIN, S_FIN
  } state_e;

  localparam int RW = prr_pkg::RES_CNT_W;

  state_e        state_q;
  logic [RW-1:0] n_q;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (command_i)
            prr_pkg::CMD_COEF:  cmd_o.coef_wr   = 1'b1;
            prr_pkg::CMD_PUSH:  cmd_o.push_smp  = !sts_i.flushing;
            prr_pkg::CMD_FLUSH: cmd_o.push_zero = 1'b1;
            default: ;
          endcase
        end
      end
      S_TGT:      cmd_o.div_tgt_start  = 1'b1;
      S_TGT_W:    cmd_o.cap_tgt        = sts_i.div_done;
      S_CHK:      cmd_o.div_base_start = !sts_i.stop_tgt;
      S_BASE_W:   cmd_o.cap_base       = sts_i.div_done;
      S_EMIT_MID: cmd_o.emit           = sts_i.out_free;
      S_MAC_INIT: cmd_o.mac_init       = 1'b1;
      S_MAC:      cmd_o.mac_issue      = 1'b1;
      S_DRAIN:    cmd_o.produce        = !sts_i.mac_busy;
      S_FIN: begin
        cmd_o.emit      = sts_i.held && sts_i.out_free;
        cmd_o.emit_last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      n_q     <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          n_q <= '0;
          if (in_valid_i) begin
            if (command_i == prr_pkg::CMD_FLUSH ||
                (command_i == prr_pkg::CMD_PUSH && !sts_i.flushing)) begin
              state_q <= S_TGT;
            end
          end
        end
        S_TGT: state_q <= S_TGT_W;
        S_TGT_W: begin
          if (sts_i.div_done) state_q <= S_CHK;
        end
        S_CHK: begin
          if (sts_i.stop_tgt) state_q <= S_FIN;
          else state_q <= S_BASE_W;
        end
        S_BASE_W: begin
          if (sts_i.div_done) state_q <= S_RDY;
        end
        S_RDY: begin
          if (!sts_i.ready_ok) state_q <= S_FIN;
          else if (sts_i.held) state_q <= S_EMIT_MID;
          else state_q <= S_MAC_INIT;
        end
        S_EMIT_MID: begin
          if (sts_i.out_free) state_q <= S_MAC_INIT;
        end
        S_MAC_INIT: state_q <= S_MAC;
        S_MAC: begin
          if (sts_i.tap_last) state_q <= S_DRAIN;
        end
        S_DRAIN: begin
          if (!sts_i.mac_busy) begin
            n_q <= n_q + RW'(1);
            if (n_q == RW'(prr_pkg::RESULT_LIMIT - 1)) state_q <= S_FIN;
            else state_q <= S_CHK;
          end
        end
        S_FIN: begin
          if (!sts_i.held || sts_i.out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/polyphase_rational_resampler_top.sv =====
// polyphase rational resampler top level: one request at a time
// per sample or flush request: a division for the output target, then per output a base/phase
// division and a mac over the taps, an emit of the held output from the second
// output on, and a closing state; output register stalls hold the controller
// coefficient writes and ignored requests finish in the idle state; up to 16 outputs per request
// reset clears counters, flush flag, config to 1; memories are not cleared
module polyphase_rational_resampler_top #(
  parameter int COEF_DEPTH    = 1024,
  parameter int MAX_TAPS      = 64,
  parameter int MAX_INTERP    = 16,
  parameter int HISTORY_DEPTH = 128,
  parameter int SAMPLE_WIDTH  = 16,
  parameter int COEF_WIDTH    = 18
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [prr_pkg::CFGA_W-1:0]      cfg_index_i,
  input  logic [prr_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [prr_pkg::CMD_W-1:0]       command_i,
  input  logic [prr_pkg::CIDX_W-1:0]      coef_index_i,
  input  logic signed [COEF_WIDTH-1:0]    coef_value_i,
  input  logic signed [SAMPLE_WIDTH-1:0]  sample_value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]  out_sample_o,
  output logic                            last_in_run_o,
  output logic                            final_output_o
);

  prr_pkg::cmd_t cmd;
  prr_pkg::sts_t sts;

  prr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  prr_datapath #(
    .COEF_DEPTH    (COEF_DEPTH),
    .MAX_TAPS      (MAX_TAPS),
    .MAX_INTERP    (MAX_INTERP),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .COEF_WIDTH    (COEF_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .coef_index_i   (coef_index_i),
    .coef_value_i   (coef_value_i),
    .sample_value_i (sample_value_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .out_sample_o   (out_sample_o),
    .last_in_run_o  (last_in_run_o),
    .final_output_o (final_output_o)
  );

  a_final_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && final_output_o |-> last_in_run_o)
    else $error("final output without last flag");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.out_free && sts.held)
    else $error("emit into busy output register");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !sts.mac_busy)
    else $error("request taken while mac pipeline busy");

endmodule

// ===== tb/sv/polyphase_rational_resampler_top_tb.sv =====
// testbench of polyphase_rational_resampler_top: directed, extreme, stall, random and flush
// tests against a built-in fixed-point resampler predictor; depends on prr_pkg and the rtl
module polyphase_rational_resampler_top_tb;

  localparam logic [prr_pkg::CMD_W-1:0] CMD_NONE = 2'd3;
  localparam int HIST_N = 128;
  localparam int COEF_N = 1024;
  localparam int SETTLE = 2500;
  localparam int STALL_LIMIT = 40000;

  typedef struct packed {
    logic signed [15:0] smp;
    logic last;
    logic fin;
  } outword_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [prr_pkg::CFGA_W-1:0] cfg_index_i;
  logic [prr_pkg::CFG_W-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_ready_o;
  logic [prr_pkg::CMD_W-1:0] command_i;
  logic [prr_pkg::CIDX_W-1:0] coef_index_i;
  logic signed [17:0] coef_value_i;
  logic signed [15:0] sample_value_i;
  logic out_valid_o;
  logic out_ready_i;
  logic signed [15:0] out_sample_o;
  logic last_in_run_o;
  logic final_output_o;

  polyphase_rational_resampler_top uut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  logic signed [17:0] coef_mem [COEF_N];
  bit coef_ok [COEF_N];
  logic signed [15:0] hist_ring [HIST_N];
  longint samples_rcvd, outputs_done, pushed_total;
  bit flushing;
  logic [4:0] interp_reg;
  logic [6:0] decim_reg, taps_reg;
  outword_t pending_out[$];

  int errors, requests_sent, results_seen, idle_cycles, hold_request, hold_cnt;
  int max_burst;
  bit tx_steady, rx_steady;

  function automatic longint clampv(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint eff_l();
    return clampv(interp_reg, 1, 16);
  endfunction

  function automatic longint eff_m();
    return clampv(decim_reg, 1, prr_pkg::DECIM_LIMIT);
  endfunction

  function automatic longint eff_t();
    return clampv(taps_reg, 1, 64);
  endfunction

  function automatic bit output_avail(longint idx);
    longint n, base, used;
    n = idx + 1;
    base = n * eff_m() / eff_l();
    used = n < eff_t() ? n : eff_t();
    return base + used - 1 < pushed_total;
  endfunction

  function automatic logic signed [15:0] fir_output(longint idx);
    longint n, acc, base, ph, used, sum;
    n = idx + 1;
    acc = n * eff_m();
    base = acc / eff_l();
    ph = acc % eff_l();
    used = n < eff_t() ? n : eff_t();
    sum = 0;
    for (longint k = 0; k < used; k++) begin
      sum += longint'(hist_ring[(base + used - 1 - k) % HIST_N]) *
             longint'(coef_mem[(ph + k * eff_l()) % COEF_N]);
    end
    sum = (sum + 32768) >>> 16;
    sum = clampv(sum, -32768, 32767);
    return sum[15:0];
  endfunction

  task automatic resample_step(logic [1:0] cmd, logic [9:0] idx, logic signed [17:0] cval,
                               logic signed [15:0] sval);
    longint target;
    int n;
    outword_t burst [16];
    n = 0;
    case (cmd)
      prr_pkg::CMD_COEF: begin
        coef_mem[idx] = cval;
        coef_ok[idx] = 1'b1;
        return;
      end
      prr_pkg::CMD_PUSH: begin
        if (flushing) return;
        hist_ring[pushed_total % HIST_N] = sval;
        pushed_total++;
        samples_rcvd++;
      end
      prr_pkg::CMD_FLUSH: begin
        flushing = 1'b1;
        hist_ring[pushed_total % HIST_N] = '0;
        pushed_total++;
      end
      default: return;
    endcase
    target = (samples_rcvd * eff_l() + eff_m() - 1) / eff_m();
    while (n < prr_pkg::RESULT_LIMIT) begin
      if (flushing && outputs_done >= target) break;
      if (!output_avail(outputs_done)) break;
      burst[n].smp = fir_output(outputs_done);
      burst[n].last = 1'b0;
      outputs_done++;
      burst[n].fin = flushing && outputs_done == target;
      n++;
    end
    if (n > 0) burst[n-1].last = 1'b1;
    if (n > max_burst) max_burst = n;
    for (int j = 0; j < n; j++) pending_out.push_back(burst[j]);
  endtask

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(logic [1:0] cmd, logic [9:0] idx, logic signed [17:0] cval,
                              logic signed [15:0] sval);
    in_valid_i <= 1'b1;
    command_i <= cmd;
    coef_index_i <= idx;
    coef_value_i <= cval;
    sample_value_i <= sval;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    resample_step(cmd, idx, cval, sval);
    requests_sent++;
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_gapped(logic [1:0] cmd, logic [9:0] idx, logic signed [17:0] cval,
                             logic signed [15:0] sval);
    send_request(cmd, idx, cval, sval);
    pause(rand_gap());
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk_i);
  endtask

  task automatic apply_config(logic [6:0] l, logic [6:0] m, logic [6:0] t);
    wait_drain();
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= prr_pkg::CFG_INTERP;
    cfg_data_i <= l;
    @(posedge clk_i);
    interp_reg = l[4:0];
    cfg_index_i <= prr_pkg::CFG_DECIM;
    cfg_data_i <= m;
    @(posedge clk_i);
    decim_reg = m;
    cfg_index_i <= prr_pkg::CFG_TAPS;
    cfg_data_i <= t;
    @(posedge clk_i);
    taps_reg = t;
    cfg_we_i <= 1'b0;
    for (int j = 0; j < eff_l() * eff_t(); j++) begin
      if (!coef_ok[j]) send_request(prr_pkg::CMD_COEF, j[9:0], 18'($urandom), '0);
    end
  endtask

  // largest decimation that keeps the next output near the available history
  function automatic logic [6:0] decim_bound(longint l_eff);
    return 7'(clampv((pushed_total + 40) * l_eff / (outputs_done + 1), 1,
                     prr_pkg::DECIM_LIMIT));
  endfunction

  task automatic random_push();
    int r;
    r = $urandom_range(0, 99);
    if (r < 82) send_gapped(prr_pkg::CMD_PUSH, 10'($urandom), 18'($urandom), 16'($urandom));
    else if (r < 95) send_gapped(prr_pkg::CMD_COEF, 10'($urandom), 18'($urandom),
                                 16'($urandom));
    else send_gapped(CMD_NONE, 10'($urandom), 18'($urandom), 16'($urandom));
  endtask

  task automatic test_directed();
    logic signed [15:0] smp [10] = '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
                                     16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
                                     16'sd0, 16'sd1};
    apply_config(7'd1, 7'd1, 7'd4);
    for (int j = 0; j < 4; j++) send_request(prr_pkg::CMD_COEF, j[9:0], -18'sd131072, '0);
    foreach (smp[j]) send_gapped(prr_pkg::CMD_PUSH, '0, '0, smp[j]);
    send_gapped(CMD_NONE, 10'd1023, 18'sd131071, 16'sd32767);
    send_gapped(prr_pkg::CMD_COEF, 10'd1023, 18'sd131071, '0);
    send_gapped(prr_pkg::CMD_COEF, 10'd1, 18'sd131071, '0);
    for (int j = 0; j < 4; j++)
      send_gapped(prr_pkg::CMD_PUSH, '0, '0, j[0] ? 16'sd32767 : -16'sd32768);
  endtask

  task automatic test_extreme_config();
    apply_config(7'd31, 7'd127, 7'd0);
    repeat (20) random_push();
    apply_config(7'd0, 7'd0, 7'd127);
    repeat (20) random_push();
    apply_config(7'd16, decim_bound(16), 7'd8);
    repeat (20) random_push();
  endtask

  task automatic test_backpressure();
    apply_config(7'd16, 7'd1, 7'd3);
    hold_request = 400;
    tx_steady = 1'b1;
    repeat (40) send_request(prr_pkg::CMD_PUSH, '0, '0, 16'($urandom));
    tx_steady = 1'b0;
    wait_drain();
  endtask

  task automatic test_random_phases();
    logic [6:0] l, t;
    longint l_eff;
    for (int ph = 0; ph < 10; ph++) begin
      if ($urandom_range(0, 3) == 0) begin
        l = 7'($urandom_range(0, 1));
        t = 7'($urandom_range(0, 127));
      end else begin
        l = 7'($urandom_range(0, 31));
        t = 7'($urandom_range(1, 8));
      end
      l_eff = clampv(l[4:0], 1, 16);
      apply_config(l, ($urandom_range(0, 9) == 0) ? 7'd0 :
                   7'($urandom_range(1, decim_bound(l_eff))), t);
      tx_steady = ph[0];
      rx_steady = ph[1];
      repeat (20) random_push();
      tx_steady = 1'b0;
      rx_steady = 1'b0;
    end
  endtask

  task automatic test_flush();
    longint m;
    int cap;
    wait_drain();
    m = clampv(samples_rcvd * 16 / (outputs_done + 20), 1, prr_pkg::DECIM_LIMIT);
    apply_config(7'd16, 7'(m), 7'd4);
    repeat (10) random_push();
    cap = 0;
    send_gapped(prr_pkg::CMD_FLUSH, '0, '0, 16'($urandom));
    send_gapped(prr_pkg::CMD_PUSH, '0, '0, 16'($urandom));
    send_gapped(CMD_NONE, '0, '0, '0);
    send_gapped(prr_pkg::CMD_COEF, 10'd5, 18'($urandom), '0);
    while (outputs_done < (samples_rcvd * eff_l() + eff_m() - 1) / eff_m() && cap < 400) begin
      send_gapped(prr_pkg::CMD_FLUSH, 10'($urandom), 18'($urandom), 16'($urandom));
      cap++;
    end
    repeat (3) send_gapped(prr_pkg::CMD_FLUSH, '0, '0, '0);
    send_gapped(prr_pkg::CMD_PUSH, '0, '0, 16'sd32767);
  endtask

  // receiver side
  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      hold_cnt = hold_request;
      hold_request = 0;
    end else if (hold_cnt == 0 && !rx_steady && $urandom_range(0, 199) == 0) begin
      hold_cnt = $urandom_range(5, 30);
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready_i <= 1'b0;
    end else if (rx_steady) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= $urandom_range(0, 99) < 70;
    end
  end

  // result checking
  always @(posedge clk_i) begin
    outword_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_out.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output %0d", out_sample_o);
      end else begin
        want = pending_out.pop_front();
        if (want.smp !== out_sample_o || want.last !== last_in_run_o ||
            want.fin !== final_output_o) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %0d/%b/%b got %0d/%b/%b", want.smp, want.last,
                     want.fin, out_sample_o, last_in_run_o, final_output_o);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    command_i = '0;
    coef_index_i = '0;
    coef_value_i = '0;
    sample_value_i = '0;
    out_ready_i = 1'b0;
    interp_reg = 5'd1;
    decim_reg = 7'd1;
    taps_reg = 7'd1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_extreme_config();
    test_backpressure();
    test_random_phases();
    test_flush();
    wait_drain();
    repeat (SETTLE) @(posedge clk_i);
    if (pending_out.size() != 0) errors++;
    $display("sent %0d requests, checked %0d outputs, largest burst %0d", requests_sent,
             results_seen, max_burst);
    $display("covered extreme factors, saturation, stalls, ignored requests and flush");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/prr_pkg.sv
sv/prr_div.sv
sv/prr_datapath.sv
sv/prr_ctrl.sv
sv/polyphase_rational_resampler_top.sv
tb/sv/polyphase_rational_resampler_top_tb.sv
